### rtl/rsi_pkg.sv
package rsi_pkg;

   // fixed field and register widths
   localparam int SYMBOL_BITS    = 8;
   localparam int DIGIT_BITS     = 4;
   localparam int ALPHABET_SLOTS = 16;
   localparam int LENGTH_BITS    = 5;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_ALPHABET_LOW    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ALPHABET_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ALPHABET_LENGTH = 2'd2;

   // reserved symbols
   localparam logic [SYMBOL_BITS-1:0] PLUS_CHAR  = 8'h2B;
   localparam logic [SYMBOL_BITS-1:0] MINUS_CHAR = 8'h2D;
   localparam logic [SYMBOL_BITS-1:0] NUL_CHAR   = 8'h00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PUSH,
      ST_SIGN,
      ST_READ,
      ST_EMIT
   } rsi_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic push;
      logic emit_sign;
      logic read;
      logic emit_digit;
   } rsi_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic alph_ok;
      logic div_last;
      logic quot_zero;
      logic negative;
      logic count_zero;
      logic out_free;
   } rsi_status_type;

endpackage

### rtl/rsi_ram.sv
module rsi_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rsi_ctrl.sv
module rsi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  rsi_pkg::rsi_status_type status,
   output rsi_pkg::rsi_cmd_type    cmd
);

   import rsi_pkg::*;

   rsi_state_type state_ff;
   rsi_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // a request with a bad alphabet is taken and dropped
            req_tready = 1'b1;
            if (req_tvalid && status.alph_ok) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            if (!status.quot_zero) begin
               state_in = ST_DIVIDE;
            end else if (status.negative) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               state_in       = status.count_zero ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/rsi_datapath.sv
module rsi_datapath #(
   parameter int MAX_SYMBOLS = 16,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rsi_pkg::rsi_cmd_type                 cmd,
   output rsi_pkg::rsi_status_type              status,
   input  logic [VALUE_BITS-1:0]                value,
   input  logic                                 csr_wr_en,
   input  logic [rsi_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rsi_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rsi_pkg::SYMBOL_BITS-1:0]      rsp_symbol,
   output logic                                 rsp_last
);

   import rsi_pkg::*;

   localparam int AW = $clog2(VALUE_BITS);
   localparam int CW = $clog2(VALUE_BITS + 1);
   localparam int BW = $clog2(VALUE_BITS);

   logic [CSR_DATA_BITS-1:0] alph_low_ff, alph_low_in;
   logic [CSR_DATA_BITS-1:0] alph_high_ff, alph_high_in;
   logic [LENGTH_BITS-1:0]   alph_len_ff, alph_len_in;
   logic [VALUE_BITS-1:0]    mag_ff, mag_in;
   logic [LENGTH_BITS-1:0]   rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   logic [BW-1:0]            bit_ff, bit_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     out_valid_ff, out_valid_in;
   logic [SYMBOL_BITS-1:0]   out_symbol_ff, out_symbol_in;
   logic                     out_last_ff, out_last_in;

   logic [SYMBOL_BITS-1:0]   sym [ALPHABET_SLOTS];
   logic                     alph_bad;
   logic [LENGTH_BITS-1:0]   rem_sh;
   logic                     rem_ge;
   logic [CW-1:0]            count_dec;
   logic [DIGIT_BITS-1:0]    rd_digit;
   logic                     out_free;

   // alphabet symbols by digit value
   always_comb begin
      for (int k = 0; k < ALPHABET_SLOTS / 2; k++) begin
         sym[k]                      = alph_low_ff[k*SYMBOL_BITS +: SYMBOL_BITS];
         sym[k + ALPHABET_SLOTS / 2] = alph_high_ff[k*SYMBOL_BITS +: SYMBOL_BITS];
      end
   end

   // alphabet check: length range, reserved bytes, repeats
   always_comb begin
      alph_bad = (alph_len_ff < LENGTH_BITS'(2)) ||
                 (alph_len_ff > LENGTH_BITS'(MAX_SYMBOLS));
      for (int i = 0; i < ALPHABET_SLOTS; i++) begin
         if (LENGTH_BITS'(i) < alph_len_ff) begin
            if (sym[i] == PLUS_CHAR || sym[i] == MINUS_CHAR || sym[i] == NUL_CHAR) begin
               alph_bad = 1'b1;
            end
            for (int j = i + 1; j < ALPHABET_SLOTS; j++) begin
               if (LENGTH_BITS'(j) < alph_len_ff && sym[i] == sym[j]) begin
                  alph_bad = 1'b1;
               end
            end
         end
      end
   end

   // restoring division step, one quotient bit per cycle
   assign rem_sh    = {rem_ff[DIGIT_BITS-1:0], mag_ff[VALUE_BITS-1]};
   assign rem_ge    = (rem_sh >= alph_len_ff);
   assign count_dec = count_ff - 1'b1;
   assign out_free  = !out_valid_ff || rsp_tready;

   // digit stack
   rsi_ram #(
      .WIDTH (DIGIT_BITS),
      .DEPTH (VALUE_BITS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (rem_ff[DIGIT_BITS-1:0]),
      .rd_en   (cmd.read),
      .rd_addr (count_dec[AW-1:0]),
      .rd_data (rd_digit)
   );

   // next values
   always_comb begin
      alph_low_in   = alph_low_ff;
      alph_high_in  = alph_high_ff;
      alph_len_in   = alph_len_ff;
      mag_in        = mag_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      bit_in        = bit_ff;
      count_in      = count_ff;
      out_valid_in  = out_valid_ff;
      out_symbol_in = out_symbol_ff;
      out_last_in   = out_last_ff;

      // configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            REG_ALPHABET_LOW:    alph_low_in  = csr_wdata;
            REG_ALPHABET_HIGH:   alph_high_in = csr_wdata;
            REG_ALPHABET_LENGTH: alph_len_in  = csr_wdata[LENGTH_BITS-1:0];
            default: ;
         endcase
      end

      // start of a request: sign and magnitude
      if (cmd.load) begin
         neg_in   = value[VALUE_BITS-1];
         mag_in   = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
         rem_in   = '0;
         bit_in   = '0;
         count_in = '0;
      end

      if (cmd.div_step) begin
         rem_in = rem_ge ? (rem_sh - alph_len_ff) : rem_sh;
         mag_in = {mag_ff[VALUE_BITS-2:0], rem_ge};
         bit_in = status.div_last ? '0 : bit_ff + 1'b1;
      end

      if (cmd.push) begin
         count_in = count_ff + 1'b1;
         rem_in   = '0;
      end

      if (cmd.read) begin
         count_in = count_dec;
      end

      // output register
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit_sign) begin
         out_valid_in  = 1'b1;
         out_symbol_in = MINUS_CHAR;
         out_last_in   = 1'b0;
      end
      if (cmd.emit_digit) begin
         out_valid_in  = 1'b1;
         out_symbol_in = sym[rd_digit];
         out_last_in   = status.count_zero;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alph_low_ff  <= '0;
         alph_high_ff <= '0;
         alph_len_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         alph_low_ff  <= alph_low_in;
         alph_high_ff <= alph_high_in;
         alph_len_ff  <= alph_len_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      mag_ff        <= mag_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      bit_ff        <= bit_in;
      count_ff      <= count_in;
      out_symbol_ff <= out_symbol_in;
      out_last_ff   <= out_last_in;
   end

   // status
   always_comb begin
      status.alph_ok    = !alph_bad;
      status.div_last   = (bit_ff == BW'(VALUE_BITS - 1));
      status.quot_zero  = (mag_ff == '0);
      status.negative   = neg_ff;
      status.count_zero = (count_ff == '0);
      status.out_free   = out_free;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_symbol = out_symbol_ff;
   assign rsp_last   = out_last_ff;

endmodule

### rtl/signed_integer_to_radix_symbols.sv
// each digit takes a full bit-serial division pass over the value and a push onto
//   the digit stack; then a minus sign, if negative, and each digit symbol is read
//   back out of the digit stack and emitted, waiting while the output is stalled
// throughput: one request at a time; the division loop yields one quotient bit per cycle
// reset: synchronous, active high; clears the alphabet registers and the output
//   register, the digit stack needs no clearing
module signed_integer_to_radix_symbols #(
   parameter int MAX_SYMBOLS = 16,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // value
   input  logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // symbol
   output logic [rsi_pkg::SYMBOL_BITS-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [rsi_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rsi_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   import rsi_pkg::*;

   rsi_cmd_type    cmd;
   rsi_status_type status;

   rsi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rsi_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .value      (req_tdata[VALUE_BITS-1:0]),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_symbol (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule

### rtl/rsi_checker.sv
module rsi_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [rsi_pkg::SYMBOL_BITS-1:0]     rsp_tdata,
   input logic                                rsp_tlast
);

   import rsi_pkg::*;

   // a stalled symbol holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // no new request while a run is still open
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken in the middle of a run");

   // a minus sign never ends a run
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == MINUS_CHAR |-> !rsp_tlast)
      else $error("minus sign flagged as last");

   // output register empty out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind signed_integer_to_radix_symbols rsi_checker u_checker (.*);
